@@ sv/idfq_pkg.sv @@
package idfq_pkg;

  // Field widths of the stream payload
  localparam int unsigned ID_W     = 16;
  localparam int unsigned STATUS_W = 2;

  // Default sizing
  localparam int unsigned FREE_DEPTH_DEF = 256;
  localparam int unsigned ID_BITS_DEF    = 16;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // Result of one command as decided by the control logic
  typedef struct packed {
    logic            from_mem; // granted ID comes from the RAM read port
    logic [ID_W-1:0] grant;
    status_e         status;
  } res_t;

endpackage

@@ sv/id_allocator_with_free_queue.sv @@
// Channel   Dir  tdata                   tuser
// s_axis    in   [15:0] freed_id         [0] command (0 allocate, 1 free)
// m_axis    out  [15:0] granted_id       [1:0] status (0 ok, 1 exhausted, 2 full)
//
// One command is taken per cycle while s_axis_tready is high; its result passes
// through the RAM read/decode stage (stage 1), then the output register, before it is offered.
// A pop reads the free-ID RAM through its registered read port, alongside stage 1.
// Reset clears pointers, count and the fresh-ID counter; the
// RAM contents are not cleared. A stalled output holds one result in the output
// register and one in stage 1 before s_axis_tready drops.
module id_allocator_with_free_queue #(
  parameter int unsigned FREE_DEPTH = idfq_pkg::FREE_DEPTH_DEF,
  parameter int unsigned ID_BITS    = idfq_pkg::ID_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [idfq_pkg::ID_W-1:0]     s_axis_tdata,  // [15:0] freed_id
  input  logic [0:0]                    s_axis_tuser,  // [0] command
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [idfq_pkg::ID_W-1:0]     m_axis_tdata,  // [15:0] granted_id
  output logic [idfq_pkg::STATUS_W-1:0] m_axis_tuser   // [1:0] status
);
  import idfq_pkg::*;

  // Stored IDs keep only the bits that survive the ID_BITS mask
  localparam int unsigned STORE_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int unsigned PTR_W   = $clog2(FREE_DEPTH);

  logic               accept;
  logic               ready;
  res_t               res;
  logic               we, re;
  logic [PTR_W-1:0]   waddr, raddr;
  logic [STORE_W-1:0] wdata, rdata;

  assign s_axis_tready = ready;
  assign accept        = s_axis_tvalid && ready;

  idfq_ctrl #(
    .FREE_DEPTH (FREE_DEPTH),
    .ID_BITS    (ID_BITS),
    .STORE_W    (STORE_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cmd_i      (cmd_e'(s_axis_tuser)),
    .freed_id_i (s_axis_tdata),
    .res_o      (res),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr)
  );

  idfq_ram #(
    .DEPTH (FREE_DEPTH),
    .WIDTH (STORE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  idfq_out #(
    .STORE_W (STORE_W)
  ) u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .res_i         (res),
    .rdata_i       (rdata),
    .ready_o       (ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

@@ sv/idfq_ram.sv @@
module idfq_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds its data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/idfq_ctrl.sv @@
module idfq_ctrl #(
  parameter int unsigned FREE_DEPTH = idfq_pkg::FREE_DEPTH_DEF,
  parameter int unsigned ID_BITS    = idfq_pkg::ID_BITS_DEF,
  parameter int unsigned STORE_W    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  idfq_pkg::cmd_e                cmd_i,
  input  logic [idfq_pkg::ID_W-1:0]     freed_id_i,
  output idfq_pkg::res_t                res_o,
  output logic                          we_o,
  output logic [$clog2(FREE_DEPTH)-1:0] waddr_o,
  output logic [STORE_W-1:0]            wdata_o,
  output logic                          re_o,
  output logic [$clog2(FREE_DEPTH)-1:0] raddr_o
);
  import idfq_pkg::*;

  localparam int unsigned PTR_W = $clog2(FREE_DEPTH);
  localparam int unsigned CNT_W = $clog2(FREE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FREE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FREE_DEPTH);
  localparam logic [ID_BITS-1:0] ID_MAX = '1;

  logic [PTR_W-1:0]   head_q, head_d;
  logic [PTR_W-1:0]   tail_q, tail_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [ID_BITS-1:0] highest_q, highest_d;
  logic [31:0]        next_wide;
  logic               empty, full;

  assign empty     = (count_q == '0);
  assign full      = (count_q == CNT_FULL);
  assign next_wide = 32'(highest_q + ID_BITS'(1));

  // Command decode and pointer update
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    highest_d = highest_q;
    res_o     = '{from_mem: 1'b0, grant: '0, status: ST_OK};
    we_o      = 1'b0;
    re_o      = 1'b0;
    if (accept_i) begin
      unique case (cmd_i)
        CMD_ALLOC: begin
          if (!empty) begin
            // pop oldest freed ID, data arrives next cycle
            re_o         = 1'b1;
            res_o.from_mem = 1'b1;
            head_d       = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
            count_d      = count_q - CNT_W'(1);
          end else if (highest_q == ID_MAX) begin
            res_o.status = ST_EXHAUSTED;
          end else begin
            highest_d   = highest_q + ID_BITS'(1);
            res_o.grant = next_wide[ID_W-1:0];
          end
        end
        CMD_FREE: begin
          if (full) begin
            res_o.status = ST_FULL;
          end else begin
            we_o    = 1'b1;
            tail_d  = (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
            count_d = count_q + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign waddr_o = tail_q;
  assign raddr_o = head_q;
  assign wdata_o = freed_id_i[STORE_W-1:0];

  // FIFO pointers and fresh-ID counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      highest_q <= '0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      highest_q <= highest_d;
    end
  end

endmodule

@@ sv/idfq_out.sv @@
module idfq_out #(
  parameter int unsigned STORE_W = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  idfq_pkg::res_t                    res_i,
  input  logic [STORE_W-1:0]                rdata_i,
  output logic                              ready_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [idfq_pkg::ID_W-1:0]         m_axis_tdata,
  output logic [idfq_pkg::STATUS_W-1:0]     m_axis_tuser
);
  import idfq_pkg::*;

  logic            s1_valid_q, s1_valid_d;
  res_t            s1_q;
  logic            out_valid_q, out_valid_d;
  logic [ID_W-1:0] out_grant_q;
  status_e         out_status_q;
  logic            s1_move;
  logic [ID_W-1:0] grant_sel;

  // Stage 1 waits for RAM data, then moves into the output register
  assign s1_move = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign ready_o = !s1_valid_q || s1_move;

  assign grant_sel = s1_q.from_mem ? ID_W'(rdata_i) : s1_q.grant;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q <= res_i;
    end
    if (s1_move) begin
      out_grant_q  <= grant_sel;
      out_status_q <= s1_q.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_grant_q;
  assign m_axis_tuser  = out_status_q;

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import idfq_pkg::*;

  // Block sizing under test (the defaults of the block)
  localparam int unsigned POOL_DEPTH   = FREE_DEPTH_DEF;
  localparam int unsigned POOL_ID_BITS = ID_BITS_DEF;
  localparam logic [ID_W-1:0] ID_MASK    = ID_W'((64'd1 << POOL_ID_BITS) - 1);
  localparam logic [ID_W-1:0] ID_CEILING = ID_MASK;
  localparam int unsigned MAX_PRINTED   = 40;

  // One predicted result of a command
  typedef struct packed {
    logic [ID_W-1:0] grant;
    status_e         status;
  } grant_result_t;

  // Predicts the granted ID and status of every accepted command and checks
  // each transaction leaving the block against the oldest prediction.
  class id_pool_scoreboard;
    logic [ID_W-1:0] freed_queue[$];   // predicted free-ID FIFO, oldest first
    logic [ID_W-1:0] fresh_top;        // highest fresh ID issued so far
    logic [ID_W-1:0] held_ids[$];      // IDs granted and not yet handed back
    grant_result_t   pending_grants[$];
    int unsigned     accepted, checked, errors;
    int unsigned     n_reused, n_exhausted, n_full;

    function new();
      fresh_top = '0;
    endfunction

    // Work out the result of one accepted command and advance the pool state
    function void predict_grant(cmd_e cmd, logic [ID_W-1:0] freed_id);
      grant_result_t r;
      r.grant  = '0;
      r.status = ST_OK;
      accepted++;
      if (cmd == CMD_ALLOC) begin
        if (freed_queue.size() > 0) begin
          r.grant = freed_queue.pop_front();
          n_reused++;
        end else if (fresh_top >= ID_CEILING) begin
          r.status = ST_EXHAUSTED;
          n_exhausted++;
        end else begin
          fresh_top++;
          r.grant = fresh_top;
        end
        if (r.status == ST_OK) begin
          held_ids.push_back(r.grant);
          if (held_ids.size() > 512) void'(held_ids.pop_front());
        end
      end else begin
        if (freed_queue.size() >= POOL_DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          freed_queue.push_back(freed_id & ID_MASK);
        end
      end
      pending_grants.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Compare one result transaction with the oldest prediction
    task check_result(logic [ID_W-1:0] grant, logic [STATUS_W-1:0] status);
      grant_result_t want;
      if (pending_grants.size() == 0) begin
        report($sformatf("result id=%h status=%0d with nothing outstanding", grant, status));
        return;
      end
      want = pending_grants.pop_front();
      checked++;
      if (grant !== want.grant)
        report($sformatf("result %0d: granted id %h, expected %h", checked, grant, want.grant));
      if (status !== want.status)
        report($sformatf("result %0d: status %0d, expected %0d (%s)", checked, status,
                         want.status, want.status.name()));
    endtask

    function int unsigned outstanding();
      return pending_grants.size();
    endfunction

    function int unsigned queued();
      return freed_queue.size();
    endfunction

    // Hand back a random held ID, or a random value if none is held
    function logic [ID_W-1:0] take_held();
      int unsigned     idx;
      logic [ID_W-1:0] v;
      if (held_ids.size() == 0) return ID_W'($urandom);
      idx = $urandom_range(0, held_ids.size() - 1);
      v   = held_ids[idx];
      held_ids.delete(idx);
      return v;
    endfunction
  endclass

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ID_W-1:0]     s_axis_tdata  = '0;
  logic [0:0]          s_axis_tuser  = CMD_ALLOC;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [ID_W-1:0]     m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;

  id_pool_scoreboard sb = new();
  int unsigned       burst_left = 0;
  int unsigned       rx_hold    = 0;

  id_allocator_with_free_queue #(
    .FREE_DEPTH(POOL_DEPTH),
    .ID_BITS   (POOL_ID_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [15:0] freed_id
    .s_axis_tuser (s_axis_tuser),   // [0] command
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [15:0] granted_id
    .m_axis_tuser (m_axis_tuser)    // [1:0] status
  );

  always #1ns clk_i = ~clk_i;

  // Receiver: short stalls mixed with long stretches of readiness
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else if ($urandom_range(0, 9) < 3) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= $urandom_range(0, 4);
    end else begin
      m_axis_tready <= 1'b1;
      rx_hold       <= $urandom_range(0, 24);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Send one command; bursts of random length with random gaps between them
  task automatic issue(cmd_e cmd, logic [ID_W-1:0] id);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= ID_W'($urandom);
        s_axis_tuser  <= 1'($urandom);
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= id;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.predict_grant(cmd, id);
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic wait_all_done();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  // Random mix in segments biased towards frees, allocates or neither
  task automatic random_run(int unsigned n_items);
    int unsigned     left, seg_left, free_pct, pick;
    cmd_e            cmd;
    logic [ID_W-1:0] id;
    left     = n_items;
    seg_left = 0;
    free_pct = 50;
    while (left > 0) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 400);
        case ($urandom_range(0, 2))
          0:       free_pct = 90;
          1:       free_pct = 10;
          default: free_pct = 50;
        endcase
      end
      seg_left--;
      left--;
      cmd  = ($urandom_range(1, 100) <= free_pct) ? CMD_FREE : CMD_ALLOC;
      pick = $urandom_range(0, 7);
      case (pick)
        0:       id = '0;
        1:       id = '1;
        default: id = ID_W'($urandom);
      endcase
      if (cmd == CMD_FREE && pick >= 2 && pick <= 4) id = sb.take_held();
      issue(cmd, id);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fresh IDs, extreme and zero IDs queued and reused in order
    issue(CMD_ALLOC, '0);
    issue(CMD_ALLOC, '1);
    issue(CMD_FREE, 16'h0000);
    issue(CMD_FREE, 16'hFFFF);
    issue(CMD_FREE, 16'h5555);
    issue(CMD_FREE, 16'hAAAA);
    repeat (5) issue(CMD_ALLOC, '0);
    issue(CMD_FREE, 16'h0002);
    issue(CMD_FREE, 16'h0001);
    issue(CMD_ALLOC, 16'hFFFF);
    issue(CMD_ALLOC, 16'h5555);
    issue(CMD_ALLOC, 16'hAAAA);
    wait_all_done();

    // Fill the free queue to the brim, overflow it, then drain it so the
    // pointers wrap
    while (sb.queued() < POOL_DEPTH) issue(CMD_FREE, ID_W'($urandom));
    issue(CMD_FREE, 16'hFFFF);
    issue(CMD_FREE, 16'h0000);
    while (sb.queued() > 0) issue(CMD_ALLOC, ID_W'($urandom));

    random_run(1000);
    wait_all_done();

    // Directed: freed IDs, zero among them, granted again straight after
    issue(CMD_ALLOC, '0);
    issue(CMD_ALLOC, '1);
    issue(CMD_FREE, 16'h1234);
    issue(CMD_ALLOC, '0);
    issue(CMD_ALLOC, '0);
    issue(CMD_FREE, 16'h0000);
    issue(CMD_ALLOC, '0);
    issue(CMD_ALLOC, '0);
    wait_all_done();

    random_run(350);

    // Drain, then give any stray result time to show up
    wait_all_done();
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d commands: %0d grants of queued IDs, %0d exhausted, %0d full drops.",
             sb.accepted, sb.n_reused, sb.n_exhausted, sb.n_full);
    $display("%0d results checked, %0d mismatches, %0d still outstanding.",
             sb.checked, sb.errors, sb.outstanding());
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("** id_allocator_with_free_queue: PASSED **");
    end else begin
      $display("** id_allocator_with_free_queue: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("Timeout with %0d results outstanding.", sb.outstanding());
    $display("** id_allocator_with_free_queue: FAILED **");
    $finish;
  end

endmodule

@@ id_allocator_with_free_queue.f @@
sv/idfq_pkg.sv
sv/idfq_ram.sv
sv/idfq_ctrl.sv
sv/idfq_out.sv
sv/id_allocator_with_free_queue.sv
tb/tb.sv
